>>> rtl/core/msc_pkg.sv
// Shared types, constants and case tables for the marching squares contour block.
package msc_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int IDX_W          = 10;
    localparam int COORD_W        = 19;
    localparam int SIDE_W         = 8;
    localparam int ROWS_MAX       = 1024;

    localparam logic [10:0]       PPR_RESET  = 11'd1024;
    localparam logic [10:0]       ROWS_RESET = 11'd768;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PPR  = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_SIDE = 2'd2
    } t_cfg_idx;

    // Edge midpoints of a cell: top, right, bottom, left.
    typedef enum logic [1:0] {
        EP_T = 2'd0,
        EP_R = 2'd1,
        EP_B = 2'd2,
        EP_L = 2'd3
    } t_ep;

    typedef struct packed {
        logic               has_cell;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [SIDE_W-1:0]  side;
        logic               c;
        logic               d;
    } t_cell_req;

    typedef struct packed {
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } t_seg;

    function automatic logic [1:0] seg_count(input logic [3:0] cs);
        logic [1:0] n;
        case (cs)
            4'd0, 4'd15: n = 2'd0;
            4'd5, 4'd10: n = 2'd2;
            default:     n = 2'd1;
        endcase
        return n;
    endfunction

    // Start and end of the first segment, then of the second, two bits each.
    function automatic logic [7:0] seg_ends(input logic [3:0] cs);
        logic [7:0] e;
        unique case (cs)
            4'd1:    e = {EP_L, EP_B, EP_T, EP_T};
            4'd2:    e = {EP_R, EP_B, EP_T, EP_T};
            4'd3:    e = {EP_L, EP_R, EP_T, EP_T};
            4'd4:    e = {EP_T, EP_R, EP_T, EP_T};
            4'd5:    e = {EP_T, EP_R, EP_L, EP_B};
            4'd6:    e = {EP_T, EP_B, EP_T, EP_T};
            4'd7:    e = {EP_T, EP_L, EP_T, EP_T};
            4'd8:    e = {EP_T, EP_L, EP_T, EP_T};
            4'd9:    e = {EP_T, EP_B, EP_T, EP_T};
            4'd10:   e = {EP_T, EP_L, EP_R, EP_B};
            4'd11:   e = {EP_T, EP_R, EP_T, EP_T};
            4'd12:   e = {EP_L, EP_R, EP_T, EP_T};
            4'd13:   e = {EP_R, EP_B, EP_T, EP_T};
            4'd14:   e = {EP_L, EP_B, EP_T, EP_T};
            default: e = {EP_T, EP_T, EP_T, EP_T};
        endcase
        return e;
    endfunction

    function automatic logic [SIDE_W:0] ep_dx(input t_ep ep, input logic [SIDE_W-1:0] side);
        logic [SIDE_W:0] v;
        case (ep)
            EP_T, EP_B: v = {1'b0, side};
            EP_R:       v = {side, 1'b0};
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [SIDE_W:0] ep_dy(input t_ep ep, input logic [SIDE_W-1:0] side);
        logic [SIDE_W:0] v;
        case (ep)
            EP_R, EP_L: v = {1'b0, side};
            EP_B:       v = {side, 1'b0};
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/msc_line_store.sv
// Line store holding the previous row of grid points, read and rewritten in the same cycle.
module msc_line_store #(
    parameter int DEPTH = msc_pkg::MAX_POINTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_wdata,
    output logic                     o_rdata
);
    logic r_mem [DEPTH];
    logic r_rdata;

    // The old entry is read out while the new point replaces it.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata      <= r_mem[i_addr];
            r_mem[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/msc_raster_ctrl.sv
// Configuration registers, raster position counters and cell origin accumulators.
module msc_raster_ctrl #(
    parameter int MAX_POINTS_PER_ROW = msc_pkg::MAX_POINTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [msc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_fire,
    input  logic                                  i_point,
    output logic [$clog2(MAX_POINTS_PER_ROW)-1:0] o_col,
    output msc_pkg::t_cell_req                    o_req
);
    import msc_pkg::*;

    localparam int CW = $clog2(MAX_POINTS_PER_ROW);
    localparam int PW = ($clog2(MAX_POINTS_PER_ROW + 1) > CFG_DATA_W) ?
                        $clog2(MAX_POINTS_PER_ROW + 1) : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_ppr;
    logic [CFG_DATA_W-1:0] r_rows;
    logic [SIDE_W-1:0]     r_side;
    logic [CW-1:0]         r_col;
    logic [IDX_W-1:0]      r_row;
    logic [COORD_W-1:0]    r_ox;
    logic [COORD_W-1:0]    r_oy;
    logic                  r_left;

    logic [PW-1:0]         ppr_w;
    logic [PW-1:0]         ppr_c;
    logic [CFG_DATA_W-1:0] rows_c;
    logic                  col_end;
    logic                  row_end;
    logic [COORD_W-1:0]    step;

    always_comb begin
        ppr_w = PW'(r_ppr);
        if (ppr_w < PW'(2)) begin
            ppr_c = PW'(2);
        end else if (ppr_w > PW'(MAX_POINTS_PER_ROW)) begin
            ppr_c = PW'(MAX_POINTS_PER_ROW);
        end else begin
            ppr_c = ppr_w;
        end
        if (r_rows < CFG_DATA_W'(2)) begin
            rows_c = CFG_DATA_W'(2);
        end else if (r_rows > CFG_DATA_W'(ROWS_MAX)) begin
            rows_c = CFG_DATA_W'(ROWS_MAX);
        end else begin
            rows_c = r_rows;
        end
        col_end = PW'(r_col) >= (ppr_c - PW'(1));
        row_end = CFG_DATA_W'(r_row) >= (rows_c - CFG_DATA_W'(1));
        step    = COORD_W'({r_side, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr  <= PPR_RESET;
            r_rows <= ROWS_RESET;
            r_side <= SIDE_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PPR:  r_ppr  <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_SIDE: r_side <= i_cfg_data[SIDE_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_left <= 1'b0;
        end else if (i_fire) begin
            r_left <= i_point;
            if (col_end) begin
                r_col <= '0;
                r_ox  <= '0;
                if (row_end) begin
                    r_row <= '0;
                    r_oy  <= '0;
                end else begin
                    if (r_row != '0) begin
                        r_oy <= r_oy + step;
                    end
                    r_row <= r_row + IDX_W'(1);
                end
            end else begin
                if (r_col != '0) begin
                    r_ox <= r_ox + step;
                end
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_comb begin
        o_req.has_cell = (r_col != '0) && (r_row != '0);
        o_req.col      = IDX_W'(r_col - CW'(1));
        o_req.row      = r_row - IDX_W'(1);
        o_req.ox       = r_ox;
        o_req.oy       = r_oy;
        o_req.side     = r_side;
        o_req.c        = i_point;
        o_req.d        = r_left;
    end

    assign o_col = r_col;
endmodule

>>> rtl/core/msc_seg_out.sv
// Cell case evaluation stage and segment output register with room for a saddle pair.
module msc_seg_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  msc_pkg::t_cell_req i_req,
    input  logic               i_up_bit,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output msc_pkg::t_seg      o_seg,
    output logic               o_last
);
    import msc_pkg::*;

    logic      r_s1_valid;
    t_cell_req r_s1;
    logic      r_ul;
    logic      r_o_valid;
    logic      r_has_nxt;
    t_seg      r_cur;
    t_seg      r_nxt;

    logic [3:0] cs;
    logic [1:0] nseg;
    logic [7:0] ends;
    t_seg       seg0;
    t_seg       seg1;
    logic       out_fire;
    logic       load_ok;
    logic       s1_adv;

    always_comb begin
        cs   = {r_ul, i_up_bit, r_s1.c, r_s1.d};
        nseg = r_s1.has_cell ? seg_count(cs) : 2'd0;
        ends = seg_ends(cs);

        seg0.col = r_s1.col;
        seg0.row = r_s1.row;
        seg0.sx  = r_s1.ox + COORD_W'(ep_dx(t_ep'(ends[7:6]), r_s1.side));
        seg0.sy  = r_s1.oy + COORD_W'(ep_dy(t_ep'(ends[7:6]), r_s1.side));
        seg0.ex  = r_s1.ox + COORD_W'(ep_dx(t_ep'(ends[5:4]), r_s1.side));
        seg0.ey  = r_s1.oy + COORD_W'(ep_dy(t_ep'(ends[5:4]), r_s1.side));

        seg1.col = r_s1.col;
        seg1.row = r_s1.row;
        seg1.sx  = r_s1.ox + COORD_W'(ep_dx(t_ep'(ends[3:2]), r_s1.side));
        seg1.sy  = r_s1.oy + COORD_W'(ep_dy(t_ep'(ends[3:2]), r_s1.side));
        seg1.ex  = r_s1.ox + COORD_W'(ep_dx(t_ep'(ends[1:0]), r_s1.side));
        seg1.ey  = r_s1.oy + COORD_W'(ep_dy(t_ep'(ends[1:0]), r_s1.side));

        out_fire = r_o_valid && i_ready;
        load_ok  = !r_o_valid || (out_fire && !r_has_nxt);
        // Cells without a segment drain without waiting on the output side.
        s1_adv   = r_s1_valid && ((nseg == 2'd0) || load_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_ul       <= 1'b0;
        end else begin
            if (i_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_ul <= i_up_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_s1 <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_has_nxt <= 1'b0;
        end else if (s1_adv && (nseg != 2'd0)) begin
            r_o_valid <= 1'b1;
            r_has_nxt <= (nseg == 2'd2);
        end else if (out_fire) begin
            if (r_has_nxt) begin
                r_has_nxt <= 1'b0;
            end else begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && (nseg != 2'd0)) begin
            r_cur <= seg0;
            r_nxt <= seg1;
        end else if (out_fire && r_has_nxt) begin
            r_cur <= r_nxt;
        end
    end

    assign o_free  = !r_s1_valid || s1_adv;
    assign o_valid = r_o_valid;
    assign o_seg   = r_cur;
    assign o_last  = !r_has_nxt;
endmodule

>>> rtl/core/marching_squares_contour_top.sv
// A point request's first segment passes the evaluation stage, then the output register.
// One point per cycle unless a cell with segments waits for the output register; a saddle
// cell holds both segments there until taken, while the evaluation stage can still take points.
// The line store is read and rewritten at the same entry in the accept cycle.
// Reset clears counters, origins and valid flags; the line store is not cleared and
// the first row of a frame writes it before any cell reads it.
module marching_squares_contour_top #(
    parameter int MAX_POINTS_PER_ROW = msc_pkg::MAX_POINTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [msc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_point_filled,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [msc_pkg::IDX_W-1:0]        o_cell_col,
    output logic [msc_pkg::IDX_W-1:0]        o_cell_row,
    output logic [msc_pkg::COORD_W-1:0]      o_start_x,
    output logic [msc_pkg::COORD_W-1:0]      o_start_y,
    output logic [msc_pkg::COORD_W-1:0]      o_end_x,
    output logic [msc_pkg::COORD_W-1:0]      o_end_y,
    output logic                             o_last_segment
);
    import msc_pkg::*;

    localparam int CW = $clog2(MAX_POINTS_PER_ROW);

    logic          in_fire;
    logic          s1_free;
    logic          up_bit;
    logic [CW-1:0] col;
    t_cell_req     req;
    t_seg          seg;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = s1_free;
    assign in_fire     = i_in_valid && s1_free;

    msc_raster_ctrl #(
        .MAX_POINTS_PER_ROW(MAX_POINTS_PER_ROW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_fire     (in_fire),
        .i_point    (i_point_filled),
        .o_col      (col),
        .o_req      (req)
    );

    msc_line_store #(
        .DEPTH(MAX_POINTS_PER_ROW)
    ) u_store (
        .i_clk  (i_clk),
        .i_en   (in_fire),
        .i_addr (col),
        .i_wdata(i_point_filled),
        .o_rdata(up_bit)
    );

    msc_seg_out u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_req   (req),
        .i_up_bit(up_bit),
        .o_free  (s1_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_seg   (seg),
        .o_last  (o_last_segment)
    );

    assign o_cell_col = seg.col;
    assign o_cell_row = seg.row;
    assign o_start_x  = seg.sx;
    assign o_start_y  = seg.sy;
    assign o_end_x    = seg.ex;
    assign o_end_y    = seg.ey;
endmodule

>>> rtl/core/msc_checker.sv
// Port-level checks on the segment output channel, bound to the top level.
module msc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [9:0]  o_cell_col,
    input logic [9:0]  o_cell_row,
    input logic [18:0] o_start_x,
    input logic [18:0] o_end_x,
    input logic        o_last_segment
);
    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("segment valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("segment request dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_start_x) && $stable(o_end_x)
                                        && $stable(o_last_segment))
        else $error("stalled segment changed");

    // The second segment of a saddle cell follows right behind the first.
    a_saddle_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_segment |=>
            o_out_valid && $stable(o_cell_col) && $stable(o_cell_row))
        else $error("saddle pair split");
endmodule

bind marching_squares_contour_top msc_checker u_msc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_cell_col    (o_cell_col),
    .o_cell_row    (o_cell_row),
    .o_start_x     (o_start_x),
    .o_end_x       (o_end_x),
    .o_last_segment(o_last_segment)
);

>>> test/marching_squares_contour_top_test.sv
// Self-checking testbench for the marching squares contour block with a built-in segment predictor.
module marching_squares_contour_top_test;
    import msc_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE      = 6;

    typedef struct {
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic               is_last;
    } t_segment;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_point_filled;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [IDX_W-1:0]      o_cell_col;
    logic [IDX_W-1:0]      o_cell_row;
    logic [COORD_W-1:0]    o_start_x;
    logic [COORD_W-1:0]    o_start_y;
    logic [COORD_W-1:0]    o_end_x;
    logic [COORD_W-1:0]    o_end_y;
    logic                  o_last_segment;

    // Predictor copy of the registers and the scan state.
    logic [10:0]        ppr_reg  = PPR_RESET;
    logic [10:0]        rows_reg = ROWS_RESET;
    logic [SIDE_W-1:0]  side_reg = SIDE_RESET;
    logic               upper_row [0:MAX_POINTS_DEF-1];
    logic               left_pt       = 1'b0;
    logic               upper_left_pt = 1'b0;
    logic [IDX_W-1:0]   col_idx = '0;
    logic [IDX_W-1:0]   row_idx = '0;
    logic [COORD_W-1:0] org_x   = '0;
    logic [COORD_W-1:0] org_y   = '0;
    int                 written_span = 0;

    logic     points_to_send [$];
    t_segment segments_due [$];

    int   cycles = 0;
    int   mismatches = 0;
    int   points_seen = 0;
    int   segments_seen = 0;
    int   saddle_cells = 0;
    int   reg_writes = 0;
    int   in_hold = 0;
    int   out_hold = 0;
    bit   idle_on = 1'b1;
    logic point_taken = 1'b0;

    marching_squares_contour_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_point_filled (i_point_filled),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cell_col     (o_cell_col),
        .o_cell_row     (o_cell_row),
        .o_start_x      (o_start_x),
        .o_start_y      (o_start_y),
        .o_end_x        (o_end_x),
        .o_end_y        (o_end_y),
        .o_last_segment (o_last_segment)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int point_limit(input logic [10:0] v);
        if (v < 2) return 2;
        if (v > MAX_POINTS_DEF) return MAX_POINTS_DEF;
        return int'(v);
    endfunction

    function automatic logic [COORD_W-1:0] mid_dx(input t_ep ep, input logic [SIDE_W-1:0] side);
        case (ep)
            EP_T, EP_B: return {11'd0, side};
            EP_R:       return {10'd0, side, 1'b0};
            default:    return '0;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] mid_dy(input t_ep ep, input logic [SIDE_W-1:0] side);
        case (ep)
            EP_R, EP_L: return {11'd0, side};
            EP_B:       return {10'd0, side, 1'b0};
            default:    return '0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly small legal values, with the clamped and masked extremes mixed in.
    function automatic logic [10:0] pick_reg(input int typical_hi);
        case ($urandom_range(0, 19))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2047;
            3:       return 11'd1024;
            4:       return 11'($urandom_range(0, 2047));
            default: return 11'($urandom_range(2, typical_hi));
        endcase
    endfunction

    // Forms the cell that this point completes, queues its segments and advances the scan.
    task automatic predict_point(input logic pt);
        int               ppr_lim;
        int               rows_lim;
        int               n;
        logic             a;
        logic             b;
        logic [3:0]       corners;
        t_ep              st [2];
        t_ep              en [2];
        t_segment         s;
        ppr_lim  = point_limit(ppr_reg);
        rows_lim = (rows_reg < 2) ? 2 : ((rows_reg > ROWS_MAX) ? ROWS_MAX : int'(rows_reg));
        b = upper_row[col_idx];
        a = upper_left_pt;
        n = 0;
        if (col_idx >= 1 && row_idx >= 1) begin
            corners = {a, b, pt, left_pt};
            st[1] = EP_T;
            en[1] = EP_T;
            n = 1;
            case (corners)
                4'd1, 4'd14: begin st[0] = EP_L; en[0] = EP_B; end
                4'd2, 4'd13: begin st[0] = EP_R; en[0] = EP_B; end
                4'd3, 4'd12: begin st[0] = EP_L; en[0] = EP_R; end
                4'd4, 4'd11: begin st[0] = EP_T; en[0] = EP_R; end
                4'd6, 4'd9:  begin st[0] = EP_T; en[0] = EP_B; end
                4'd7, 4'd8:  begin st[0] = EP_T; en[0] = EP_L; end
                4'd5: begin
                    st[0] = EP_T; en[0] = EP_R; st[1] = EP_L; en[1] = EP_B; n = 2;
                end
                4'd10: begin
                    st[0] = EP_T; en[0] = EP_L; st[1] = EP_R; en[1] = EP_B; n = 2;
                end
                default: n = 0;
            endcase
            if (n == 2) saddle_cells++;
            for (int k = 0; k < n; k++) begin
                s.col     = col_idx - 1'b1;
                s.row     = row_idx - 1'b1;
                s.sx      = org_x + mid_dx(st[k], side_reg);
                s.sy      = org_y + mid_dy(st[k], side_reg);
                s.ex      = org_x + mid_dx(en[k], side_reg);
                s.ey      = org_y + mid_dy(en[k], side_reg);
                s.is_last = (k == n - 1);
                segments_due.push_back(s);
            end
        end

        upper_left_pt = b;
        upper_row[col_idx] = pt;
        left_pt = pt;
        if (int'(col_idx) + 1 > written_span) written_span = int'(col_idx) + 1;

        if (col_idx >= ppr_lim - 1) begin
            col_idx = '0;
            org_x = '0;
            if (row_idx >= rows_lim - 1) begin
                row_idx = '0;
                org_y = '0;
            end else begin
                if (row_idx >= 1) org_y = org_y + {10'd0, side_reg, 1'b0};
                row_idx = row_idx + 1'b1;
            end
        end else begin
            if (col_idx >= 1) org_x = org_x + {10'd0, side_reg, 1'b0};
            col_idx = col_idx + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_segment want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped at cycle %0d with %0d segments still outstanding.",
                     cycles, segments_due.size());
            $display("Mismatches found");
            $finish;
        end else begin
            point_taken = i_in_valid && o_in_ready;
            if (i_rst_n) begin
                if (i_cfg_valid && o_cfg_ready) begin
                    reg_writes++;
                    case (i_cfg_index)
                        CFG_PPR:  ppr_reg  = i_cfg_data;
                        CFG_ROWS: rows_reg = i_cfg_data;
                        CFG_SIDE: side_reg = i_cfg_data[SIDE_W-1:0];
                        default:  ;
                    endcase
                end
                if (o_out_valid && i_out_ready) begin
                    segments_seen++;
                    if (segments_due.size() == 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Unexpected segment: cell %0d,%0d (%0d,%0d)-(%0d,%0d)",
                                     o_cell_col, o_cell_row, o_start_x, o_start_y,
                                     o_end_x, o_end_y);
                    end else begin
                        want = segments_due.pop_front();
                        if (want.col !== o_cell_col || want.row !== o_cell_row ||
                            want.sx !== o_start_x || want.sy !== o_start_y ||
                            want.ex !== o_end_x || want.ey !== o_end_y ||
                            want.is_last !== o_last_segment) begin
                            mismatches++;
                            if (mismatches <= 10) begin
                                $display("Segment differs: expected cell %0d,%0d (%0d,%0d)-(%0d,%0d) last %0d",
                                         want.col, want.row, want.sx, want.sy, want.ex, want.ey,
                                         want.is_last);
                                $display("                 actual   cell %0d,%0d (%0d,%0d)-(%0d,%0d) last %0d",
                                         o_cell_col, o_cell_row, o_start_x, o_start_y,
                                         o_end_x, o_end_y, o_last_segment);
                            end
                        end
                    end
                end
                if (i_in_valid && o_in_ready) begin
                    points_seen++;
                    predict_point(i_point_filled);
                end
            end
        end
    end

    // A new point request goes out only after the current one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || point_taken) begin
            if (in_hold > 0) begin
                in_hold--;
                i_in_valid <= 1'b0;
            end else if (points_to_send.size() != 0) begin
                i_point_filled <= points_to_send.pop_front();
                i_in_valid <= 1'b1;
                in_hold = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_hold = pick_gap();
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [10:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every point is taken and every segment has arrived, then lets the pipe drain.
    task automatic wait_idle();
        while (points_to_send.size() != 0 || i_in_valid || segments_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_points(input logic [31:0] bits, input int count);
        for (int k = count - 1; k >= 0; k--) points_to_send.push_back(bits[k]);
    endtask

    initial begin
        int          n;
        int          mode;
        int          density;
        int          random_points;
        logic        run_bit;
        logic [10:0] v;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PPR;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_point_filled = 1'b0;
        i_out_ready    = 1'b0;
        random_points  = 0;
        run_bit        = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest grid through clamping, widest side: both saddle cases.
        write_reg(CFG_PPR, 11'd0);
        write_reg(CFG_ROWS, 11'd1);
        write_reg(CFG_SIDE, 11'd255);
        queue_points(32'b0110_1001, 8);
        wait_idle();

        // Widest row through clamping, filling the whole line store and starting the next row.
        write_reg(CFG_PPR, 11'd2047);
        write_reg(CFG_ROWS, 11'd2);
        repeat (MAX_POINTS_DEF + 16) points_to_send.push_back(1'($urandom_range(0, 1)));
        wait_idle();

        // Clamped row count on a narrow grid; the side write sets upper data bits that are masked off.
        write_reg(CFG_PPR, 11'd2);
        write_reg(CFG_ROWS, 11'd2047);
        write_reg(CFG_SIDE, 11'h1FF);
        repeat (64) points_to_send.push_back(1'($urandom_range(0, 1)));
        wait_idle();

        // Zero side, then side and row count change in the middle of a frame.
        write_reg(CFG_PPR, 11'd5);
        write_reg(CFG_ROWS, 11'd3);
        write_reg(CFG_SIDE, 11'd0);
        queue_points(32'b10101_01, 7);
        wait_idle();
        write_reg(CFG_SIDE, 11'd1);
        write_reg(CFG_ROWS, 11'd2);
        queue_points(32'b010_11001, 8);

        while (random_points < 850) begin
            wait_idle();
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            v = pick_reg(12);
                            // Growing the row mid frame must not expose unwritten line store.
                            if (row_idx != 0 && point_limit(v) > written_span)
                                v = 11'(written_span);
                            write_reg(CFG_PPR, v);
                        end
                        1:       write_reg(CFG_ROWS, pick_reg(8));
                        default: write_reg(CFG_SIDE, pick_reg(255));
                    endcase
                end
            end
            n = $urandom_range(8, 200);
            mode = $urandom_range(0, 3);
            density = (mode == 1) ? 15 : ((mode == 2) ? 85 : 50);
            repeat (n) begin
                if (mode == 3) begin
                    if ($urandom_range(0, 9) == 0) run_bit = ~run_bit;
                    points_to_send.push_back(run_bit);
                end else begin
                    points_to_send.push_back($urandom_range(0, 99) < density);
                end
            end
            random_points += n;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d grid points and %0d segments, %0d of the cells being saddles,",
                 points_seen, segments_seen, saddle_cells);
        $display("over %0d register writes including clamped and masked values.", reg_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
